>>> hw/rtl/fir3_pkg.sv
// fir3_pkg: shared types and constants for the three-channel fir convolver
// no dependencies; used by fir3_lane and three_channel_fir_convolver_unit
package fir3_pkg;

    // field widths fixed by the item format
    localparam int TAP_W   = 18;
    localparam int SAMP_W  = 24;
    localparam int PROD_W  = TAP_W + SAMP_W;
    localparam int ACC_W   = 48;
    localparam int OFS_W   = 25;
    localparam int POS_W   = 24;
    localparam int IDX_W   = 5;
    localparam int TIN_W   = 6;
    localparam int ZL_W    = 5;
    localparam int CH      = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 176;

    // config port
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam logic [TIN_W-1:0] TAPS_RESET = 6'd32;
    localparam logic [ZL_W-1:0]  ZL_RESET   = 5'd0;

    // item kind carried on tuser
    typedef enum logic {
        MODE_TAP    = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_TAPS_IN_USE  = 1'b0,
        REG_ZERO_LAG_IDX = 1'b1
    } reg_idx_t;

    // per-lane step control
    typedef struct packed {
        logic step;
        logic clear;
    } lane_ctrl_t;

endpackage

>>> hw/rtl/three_channel_fir_convolver_unit.sv
// three_channel_fir_convolver_unit: top level, input register, tap store, offset
// counter, tail flush control and result register; depends on fir3_pkg, fir3_lane
//
// a sample item passes through the input register and then the result register
// throughput: one item per cycle while the result side does not stall; an
//   end-of-trace item holds the input register for taps_in_use steps, clamped
//   to 1..MAX_TAPS (one result each); a tap write makes no result
// reset: aresetn synchronous active low; clears taps, partial sums, offset
//   counter, handshake state and the config registers to their defaults
module three_channel_fir_convolver_unit #(
    parameter int MAX_TAPS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tap_index[4:0], tap_value[22:5], sample_x[46:23], sample_y[70:47],
    // sample_z[94:71], zero pad[95]
    input  logic [fir3_pkg::S_DATA_W-1:0]     s_tdata,
    // mode[0]
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x[47:0], out_y[95:48], out_z[143:96], sample_offset[168:144],
    // zero pad[175:169]
    output logic [fir3_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    // config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fir3_pkg::APB_AW-1:0]       paddr,
    input  logic [fir3_pkg::APB_DW-1:0]       pwdata,
    output logic [fir3_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int CNT_W = $clog2(MAX_TAPS);
    localparam logic [fir3_pkg::POS_W-1:0] POS_TOP = '1;

    // config registers
    logic [fir3_pkg::TIN_W-1:0] taps_reg;
    logic [fir3_pkg::ZL_W-1:0]  zl_reg;
    logic                       cfg_wr;
    fir3_pkg::reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = fir3_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= fir3_pkg::TAPS_RESET;
            zl_reg   <= fir3_pkg::ZL_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                fir3_pkg::REG_TAPS_IN_USE:  taps_reg <= pwdata[fir3_pkg::TIN_W-1:0];
                fir3_pkg::REG_ZERO_LAG_IDX: zl_reg   <= pwdata[fir3_pkg::ZL_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            fir3_pkg::REG_TAPS_IN_USE:
                prdata = {{(fir3_pkg::APB_DW-fir3_pkg::TIN_W){1'b0}}, taps_reg};
            fir3_pkg::REG_ZERO_LAG_IDX:
                prdata = {{(fir3_pkg::APB_DW-fir3_pkg::ZL_W){1'b0}}, zl_reg};
            default:
                prdata = '0;
        endcase
    end

    // active tap count clamped to 1..MAX_TAPS, kept as count minus one
    logic [6:0]       t_ext;
    logic [6:0]       t_clamp;
    logic [CNT_W-1:0] tm1;

    always_comb begin
        t_ext = {1'b0, taps_reg};
        if (t_ext == 7'd0) begin
            t_clamp = 7'd1;
        end else if (32'(t_ext) > MAX_TAPS) begin
            t_clamp = 7'(MAX_TAPS);
        end else begin
            t_clamp = t_ext;
        end
    end
    assign tm1 = CNT_W'(t_clamp - 7'd1);

    // input register
    logic                                in_valid_reg;
    fir3_pkg::mode_t                     in_mode_reg;
    logic [fir3_pkg::IDX_W-1:0]          in_idx_reg;
    logic signed [fir3_pkg::TAP_W-1:0]   in_tap_reg;
    logic signed [fir3_pkg::SAMP_W-1:0]  in_x_reg [fir3_pkg::CH];
    logic                                in_last_reg;
    logic                                s_fire;

    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_mode_reg <= fir3_pkg::mode_t'(s_tuser);
            in_idx_reg  <= s_tdata[4:0];
            in_tap_reg  <= signed'(s_tdata[22:5]);
            in_x_reg[0] <= signed'(s_tdata[46:23]);
            in_x_reg[1] <= signed'(s_tdata[70:47]);
            in_x_reg[2] <= signed'(s_tdata[94:71]);
            in_last_reg <= s_tlast;
        end
    end

    // step control
    logic             out_valid_reg;
    logic             out_free;
    logic             fire;
    logic             is_sample;
    logic             step;
    logic             at_end;
    logic             step_last;
    logic             consume;
    logic [CNT_W-1:0] step_cnt_reg;
    logic [CNT_W-1:0] step_cnt_next;

    assign out_free  = !out_valid_reg || m_tready;
    assign is_sample = (in_mode_reg == fir3_pkg::MODE_SAMPLE);
    assign fire      = in_valid_reg && (!is_sample || out_free);
    assign step      = fire && is_sample;
    assign at_end    = (step_cnt_reg == tm1);
    assign step_last = in_last_reg && at_end;
    assign consume   = fire && (!is_sample || !in_last_reg || at_end);
    assign s_tready  = !in_valid_reg || consume;

    // tail step counter, nonzero while the flush runs
    always_comb begin
        if (consume) begin
            step_cnt_next = '0;
        end else if (step) begin
            step_cnt_next = step_cnt_reg + CNT_W'(1);
        end else begin
            step_cnt_next = step_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
        end else begin
            step_cnt_reg <= step_cnt_next;
        end
    end

    // tap store
    logic signed [fir3_pkg::TAP_W-1:0]       tap_reg [MAX_TAPS];
    logic [MAX_TAPS*fir3_pkg::TAP_W-1:0]     taps_flat;
    logic                                    tap_wr;

    assign tap_wr = fire && !is_sample;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_taps
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tap_reg[k] <= '0;
            end else if (tap_wr && (32'(in_idx_reg) == k)) begin
                tap_reg[k] <= in_tap_reg;
            end
        end
        assign taps_flat[k*fir3_pkg::TAP_W +: fir3_pkg::TAP_W] = tap_reg[k];
    end

    // channel lanes, zero input during the tail flush
    fir3_pkg::lane_ctrl_t               lane_ctrl;
    logic signed [fir3_pkg::ACC_W-1:0]  lane_y [fir3_pkg::CH];

    assign lane_ctrl.step  = step;
    assign lane_ctrl.clear = step && step_last;

    for (genvar c = 0; c < fir3_pkg::CH; c++) begin : g_lane
        logic signed [fir3_pkg::SAMP_W-1:0] x_use;
        assign x_use = (step_cnt_reg == '0) ? in_x_reg[c] : '0;

        fir3_lane #(
            .MAX_TAPS (MAX_TAPS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .taps_flat (taps_flat),
            .tm1       (tm1),
            .x_in      (x_use),
            .y_out     (lane_y[c])
        );
    end

    // output position counter, saturating
    logic [fir3_pkg::POS_W-1:0] pos_reg;
    logic [fir3_pkg::POS_W-1:0] pos_next;
    logic [fir3_pkg::OFS_W-1:0] offset;

    always_comb begin
        pos_next = pos_reg;
        if (step && step_last) begin
            pos_next = '0;
        end else if (step && (pos_reg != POS_TOP)) begin
            pos_next = pos_reg + fir3_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    assign offset = {1'b0, pos_reg} - fir3_pkg::OFS_W'(zl_reg);

    // result register
    logic signed [fir3_pkg::ACC_W-1:0] out_y_reg [fir3_pkg::CH];
    logic [fir3_pkg::OFS_W-1:0]        out_ofs_reg;
    logic                              out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_y_reg[0] <= lane_y[0];
            out_y_reg[1] <= lane_y[1];
            out_y_reg[2] <= lane_y[2];
            out_ofs_reg  <= offset;
            out_last_reg <= step_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_ofs_reg, out_y_reg[2], out_y_reg[1], out_y_reg[0]};

    // flush steps only happen with a held end-of-trace sample item
    a_flush_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_cnt_reg != '0) |->
            (in_valid_reg && in_last_reg && in_mode_reg == fir3_pkg::MODE_SAMPLE))
        else $error("tail flush running without an end-of-trace item");

    // the final step of a trace restarts the position count
    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && step_last) |=> (pos_reg == '0 && m_tvalid && m_tlast))
        else $error("position not restarted after the final output");

    // a tap write never produces a result
    a_tap_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (tap_wr && !out_valid_reg) |=> !m_tvalid)
        else $error("tap write produced a result");

endmodule

>>> hw/rtl/fir3_lane.sv
// fir3_lane: one channel of the transposed-form fir, partial sum registers and
// the parallel multiply-accumulate row; depends on fir3_pkg
module fir3_lane #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  fir3_pkg::lane_ctrl_t                   ctrl,
    input  logic [MAX_TAPS*fir3_pkg::TAP_W-1:0]    taps_flat,
    input  logic [$clog2(MAX_TAPS)-1:0]            tm1,
    input  logic signed [fir3_pkg::SAMP_W-1:0]     x_in,
    output logic signed [fir3_pkg::ACC_W-1:0]      y_out
);

    localparam int CNT_W = $clog2(MAX_TAPS);

    logic signed [fir3_pkg::ACC_W-1:0]  acc_reg  [MAX_TAPS];
    logic signed [fir3_pkg::ACC_W-1:0]  acc_next [MAX_TAPS];
    logic signed [fir3_pkg::PROD_W-1:0] prod     [MAX_TAPS];
    logic signed [fir3_pkg::ACC_W-1:0]  shifted  [MAX_TAPS];

    // one product per tap, all in parallel
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
        logic signed [fir3_pkg::TAP_W-1:0] tap_k;
        assign tap_k   = signed'(taps_flat[k*fir3_pkg::TAP_W +: fir3_pkg::TAP_W]);
        assign prod[k] = tap_k * x_in;

        // sum moves one place toward the output
        if (k < MAX_TAPS - 1) begin : g_shift
            assign shifted[k] = acc_reg[k+1] + fir3_pkg::ACC_W'(prod[k+1]);
        end else begin : g_top
            assign shifted[k] = '0;
        end

        // sums from the active tap count minus one upward are cleared
        assign acc_next[k] = (CNT_W'(k) < tm1) ? shifted[k] : '0;
    end

    // completed output sample
    assign y_out = acc_reg[0] + fir3_pkg::ACC_W'(prod[0]);

    // partial sum registers
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            if (!aresetn || ctrl.clear) begin
                acc_reg[k] <= '0;
            end else if (ctrl.step) begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for three_channel_fir_convolver_unit, stream items in and out
// with random gaps and stalls, checked against a transposed-form fir predictor
// depends on fir3_pkg and the block's rtl only
module tb;

    localparam int N_TAPS = 32;
    localparam int CH = fir3_pkg::CH;
    localparam int RX_HOLD = 300;
    localparam int SETTLE = 8;
    localparam int POS_TOP = 16777215;
    localparam int T_MAX = 131071;
    localparam int T_MIN = -131072;
    localparam int S_MAX = 8388607;
    localparam int S_MIN = -8388608;

    typedef struct {
        fir3_pkg::mode_t    mode;
        logic [4:0]         tap_idx;
        logic signed [17:0] tap_val;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] sz;
        logic               eot;
    } item_t;

    typedef struct {
        logic signed [47:0] ox;
        logic signed [47:0] oy;
        logic signed [47:0] oz;
        logic signed [24:0] ofs;
        logic               last;
    } res_t;

    typedef struct {
        logic               is_cfg;
        fir3_pkg::reg_idx_t cfg_reg;
        logic [31:0]        cfg_val;
        item_t              it;
        logic               fix;
        res_t               fres;
    } row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [fir3_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [fir3_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [fir3_pkg::APB_AW-1:0]     paddr;
    logic [fir3_pkg::APB_DW-1:0]     pwdata;
    logic [fir3_pkg::APB_DW-1:0]     prdata;
    logic                            pready;

    // typed expectation carried alongside a directed item
    logic                  s_fix;
    res_t                  s_fix_res;

    // predictor state
    logic signed [17:0]    wavelet [N_TAPS];
    longint                partial_sum [CH][N_TAPS];
    int                    out_position;
    logic [5:0]            taps_cfg;
    logic [4:0]            zl_cfg;
    res_t                  pending_outputs [$];

    res_t                  no_res = '{ox: 0, oy: 0, oz: 0, ofs: 0, last: 0};
    logic                  no_idle = 1'b0;
    logic                  hold_req = 1'b0;
    int                    err_count = 0;

    three_channel_fir_convolver_unit #(
        .MAX_TAPS (N_TAPS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // tap count clamped to the range the block supports
    function automatic int taps_used();
        int t;
        t = taps_cfg;
        if (t < 1) t = 1;
        if (t > N_TAPS) t = N_TAPS;
        return t;
    endfunction

    // one transposed-form shift on all channels, queues one output sample
    function automatic void shift_sums(input longint xin [CH], input logic last);
        res_t   r;
        longint y [CH];
        int     t;
        t = taps_used();
        for (int c = 0; c < CH; c++) begin
            y[c] = partial_sum[c][0] + longint'(wavelet[0]) * xin[c];
            for (int k = 0; k + 1 < t; k++)
                partial_sum[c][k] = partial_sum[c][k+1] + longint'(wavelet[k+1]) * xin[c];
            for (int k = t - 1; k < N_TAPS; k++)
                partial_sum[c][k] = 0;
        end
        r.ox   = y[0][47:0];
        r.oy   = y[1][47:0];
        r.oz   = y[2][47:0];
        r.ofs  = 25'(out_position - int'(zl_cfg));
        r.last = last;
        if (out_position < POS_TOP) out_position++;
        pending_outputs.push_back(r);
    endfunction

    // tap write or sample; an end-of-trace sample also flushes the tail
    function automatic void convolve_item(input item_t it);
        longint xin [CH];
        longint zero_in [CH];
        int     t;
        if (it.mode == fir3_pkg::MODE_TAP) begin
            wavelet[it.tap_idx] = it.tap_val;
            return;
        end
        zero_in = '{default: 0};
        xin[0] = it.sx;
        xin[1] = it.sy;
        xin[2] = it.sz;
        t = taps_used();
        shift_sums(xin, it.eot && t == 1);
        if (it.eot) begin
            for (int i = 1; i < t; i++)
                shift_sums(zero_in, i + 1 == t);
            foreach (partial_sum[c, k]) partial_sum[c][k] = 0;
            out_position = 0;
        end
    endfunction

    initial begin
        foreach (wavelet[k]) wavelet[k] = '0;
        foreach (partial_sum[c, k]) partial_sum[c][k] = 0;
        out_position = 0;
        taps_cfg = fir3_pkg::TAPS_RESET;
        zl_cfg = fir3_pkg::ZL_RESET;
    end

    // result check first, then prediction of the item accepted at this edge
    always @(posedge aclk) begin
        res_t  want;
        item_t it;
        int    n0;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                note_mismatch("result with nothing pending", $signed(m_tdata[168:144]), 0);
            end else begin
                want = pending_outputs.pop_front();
                if ($signed(m_tdata[47:0]) !== want.ox)
                    note_mismatch("out_x", $signed(m_tdata[47:0]), want.ox);
                if ($signed(m_tdata[95:48]) !== want.oy)
                    note_mismatch("out_y", $signed(m_tdata[95:48]), want.oy);
                if ($signed(m_tdata[143:96]) !== want.oz)
                    note_mismatch("out_z", $signed(m_tdata[143:96]), want.oz);
                if ($signed(m_tdata[168:144]) !== want.ofs)
                    note_mismatch("sample_offset", $signed(m_tdata[168:144]), want.ofs);
                if (m_tlast !== want.last)
                    note_mismatch("last_out", m_tlast, want.last);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            it.mode    = fir3_pkg::mode_t'(s_tuser);
            it.tap_idx = s_tdata[4:0];
            it.tap_val = s_tdata[22:5];
            it.sx      = s_tdata[46:23];
            it.sy      = s_tdata[70:47];
            it.sz      = s_tdata[94:71];
            it.eot     = s_tlast;
            n0 = pending_outputs.size();
            convolve_item(it);
            if (s_fix && pending_outputs.size() > n0) pending_outputs[n0] = s_fix_res;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // offer one item after a random gap, return at the edge it is taken
    task automatic send_item(input item_t it, input logic fix, input res_t fres);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= it.mode;
        s_tlast   <= it.eot;
        s_tdata   <= {1'b0, it.sz, it.sy, it.sx, it.tap_val, it.tap_idx};
        s_fix     <= fix;
        s_fix_res <= fres;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering items until every pending output has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_reg(input fir3_pkg::reg_idx_t r, input logic [31:0] v);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (r == fir3_pkg::REG_TAPS_IN_USE) taps_cfg = v[5:0];
        else zl_cfg = v[4:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (rd !== v) note_mismatch("register read back", rd, v);
    endtask

    function automatic item_t mk_item(input fir3_pkg::mode_t m, input int idx, input int tv,
                                      input int x, input int y, input int z, input logic eot);
        item_t it;
        it.mode    = m;
        it.tap_idx = 5'(idx);
        it.tap_val = 18'(tv);
        it.sx      = 24'(x);
        it.sy      = 24'(y);
        it.sz      = 24'(z);
        it.eot     = eot;
        return it;
    endfunction

    function automatic row_t item_row(input item_t it);
        row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_reg = fir3_pkg::REG_TAPS_IN_USE;
        r.cfg_val = '0;
        r.it      = it;
        r.fix     = 1'b0;
        r.fres    = no_res;
        return r;
    endfunction

    function automatic row_t typed_row(input item_t it, input longint ex, input longint ey,
                                       input longint ez, input int ofs, input logic last);
        row_t r;
        r = item_row(it);
        r.fix       = 1'b1;
        r.fres.ox   = 48'(ex);
        r.fres.oy   = 48'(ey);
        r.fres.oz   = 48'(ez);
        r.fres.ofs  = 25'(ofs);
        r.fres.last = last;
        return r;
    endfunction

    function automatic row_t cfg_row(input fir3_pkg::reg_idx_t reg_sel, input int v);
        row_t r;
        r = item_row(mk_item(fir3_pkg::MODE_TAP, 0, 0, 0, 0, 0, 1'b0));
        r.is_cfg  = 1'b1;
        r.cfg_reg = reg_sel;
        r.cfg_val = v;
        return r;
    endfunction

    // extremes and zero show up often, the rest is uniform
    function automatic int pick_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_tap();
        case ($urandom_range(0, 7))
            0: return T_MAX;
            1: return T_MIN;
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_taps();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 32;
            3: return 63;
            4: return $urandom_range(1, 63);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic item_t rand_item(input fir3_pkg::mode_t m, input int idx, input logic eot);
        return mk_item(m, idx, pick_tap(), pick_sample(), pick_sample(), pick_sample(), eot);
    endfunction

    // stimulus: directed table, then random traces
    initial begin
        row_t rows [$];
        int   phase;
        int   sent;
        int   nt;
        int   len;
        logic squeeze;
        logic full;
        logic open_end;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        s_fix     = 1'b0;
        s_fix_res = no_res;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset taps are zero, so the first output is zero
        rows.push_back(typed_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MAX, S_MIN, 0, 1'b0),
                                 0, 0, 0, 0, 1'b0));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_TAP, 0, T_MAX, 0, 0, 0, 1'b0)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_TAP, 31, T_MIN, 0, 0, 0, 1'b1)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_TAP, 1, -1, 0, 0, 0, 1'b0)));
        rows.push_back(typed_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MIN, S_MAX, -1, 1'b0),
                                 longint'(T_MAX) * S_MIN, longint'(T_MAX) * S_MAX,
                                 -T_MAX, 1, 1'b0));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MAX, S_MIN, S_MAX,
                                        1'b0)));
        // full 32-tap tail flush
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MIN, S_MIN, S_MIN,
                                        1'b1)));
        // single tap with zero lag past the end: offset goes negative
        rows.push_back(cfg_row(fir3_pkg::REG_TAPS_IN_USE, 1));
        rows.push_back(cfg_row(fir3_pkg::REG_ZERO_LAG_IDX, 31));
        rows.push_back(typed_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MAX, S_MIN, 0, 1'b1),
                                 longint'(T_MAX) * S_MAX, longint'(T_MAX) * S_MIN,
                                 0, -31, 1'b1));
        // tap count of zero acts as one
        rows.push_back(cfg_row(fir3_pkg::REG_TAPS_IN_USE, 0));
        rows.push_back(cfg_row(fir3_pkg::REG_ZERO_LAG_IDX, 0));
        rows.push_back(typed_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, 1, -1, S_MIN, 1'b0),
                                 T_MAX, -T_MAX, longint'(T_MAX) * S_MIN, 0, 1'b0));
        rows.push_back(typed_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, 2, 0, S_MAX, 1'b1),
                                 2 * T_MAX, 0, longint'(T_MAX) * S_MAX, 1, 1'b1));
        // tap count above the maximum, tap writes and tap count change mid-trace
        rows.push_back(cfg_row(fir3_pkg::REG_TAPS_IN_USE, 63));
        rows.push_back(cfg_row(fir3_pkg::REG_ZERO_LAG_IDX, 5));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_TAP, 31, T_MAX, 0, 0, 0, 1'b0)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MAX, 1, S_MIN, 1'b0)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_TAP, 2, -5000, 0, 0, 0, 1'b0)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, -7, S_MAX, 12345,
                                        1'b0)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MIN, S_MAX, S_MIN,
                                        1'b0)));
        rows.push_back(cfg_row(fir3_pkg::REG_TAPS_IN_USE, 4));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, 100, -100, S_MAX,
                                        1'b0)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MAX, S_MAX, S_MAX,
                                        1'b1)));
        rows.push_back(cfg_row(fir3_pkg::REG_TAPS_IN_USE, 2));
        rows.push_back(cfg_row(fir3_pkg::REG_ZERO_LAG_IDX, 31));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_TAP, 1, T_MIN, 0, 0, 0, 1'b1)));
        rows.push_back(item_row(mk_item(fir3_pkg::MODE_SAMPLE, 0, 0, S_MIN, 3, S_MAX, 1'b1)));
        rows.push_back(cfg_row(fir3_pkg::REG_TAPS_IN_USE, 32));
        rows.push_back(cfg_row(fir3_pkg::REG_ZERO_LAG_IDX, 0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_reg(rows[i].cfg_reg, rows[i].cfg_val);
            end else begin
                send_item(rows[i].it, rows[i].fix, rows[i].fres);
            end
        end

        // random traces: optional config, wavelet load, then samples that mostly end in end-of-trace
        phase = 0;
        sent = 0;
        while (sent < 330) begin
            squeeze = (phase == 0 || phase == 12);
            no_idle = squeeze || ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                wait_idle();
                write_reg(fir3_pkg::REG_TAPS_IN_USE, pick_taps());
                write_reg(fir3_pkg::REG_ZERO_LAG_IDX, $urandom_range(0, 31));
            end
            full = ($urandom_range(0, 2) == 0);
            nt = full ? taps_used() : $urandom_range(0, 3);
            for (int k = 0; k < nt; k++) begin
                send_item(rand_item(fir3_pkg::MODE_TAP, full ? k : $urandom,
                                    $urandom_range(0, 1)),
                          1'b0, no_res);
                sent++;
            end
            // sometimes the trace is left open and runs into the next phase
            open_end = ($urandom_range(0, 7) == 0);
            len = squeeze ? 24 : $urandom_range(1, 12);
            if (squeeze) hold_req = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (!squeeze && $urandom_range(0, 15) == 0) begin
                    send_item(rand_item(fir3_pkg::MODE_TAP, $urandom, $urandom_range(0, 1)),
                              1'b0, no_res);
                    sent++;
                end
                if (!squeeze && k > 0 && $urandom_range(0, 19) == 0) begin
                    wait_idle();
                    write_reg(fir3_pkg::REG_TAPS_IN_USE, pick_taps());
                end
                send_item(rand_item(fir3_pkg::MODE_SAMPLE, $urandom,
                                    k == len - 1 && !open_end),
                          1'b0, no_res);
                sent++;
            end
            phase++;
        end

        // close any open trace so the tail drains
        no_idle = 1'b0;
        send_item(rand_item(fir3_pkg::MODE_SAMPLE, $urandom, 1'b1), 1'b0, no_res);
        wait_idle();
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
